FILE: rtl/core/tlu_pkg.sv
// Shared constants, status codes and controller/datapath interface types.
package tlu_pkg;

	localparam int DATA_W      = 32;
	localparam int FRAC_BITS   = 24;
	localparam int ROW_W       = 11;
	localparam int MAX_COLUMNS = 1024;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;

	localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef struct packed {
		logic load_in;
		logic mul_en;
		logic piv_en;
		logic div_start;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} dp_status_t;

endpackage

FILE: rtl/core/tlu_div.sv
// Iterative signed fractional divider: saturate((num << 24) / den), one quotient bit a cycle.
module tlu_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tlu_pkg::DATA_W-1:0]  dividend,
	input  logic signed [tlu_pkg::DATA_W-1:0]  divisor,
	output logic                               done,
	output logic signed [tlu_pkg::DATA_W-1:0]  quotient
);
	import tlu_pkg::*;

	localparam int HIGH_SHIFT = DATA_W - FRAC_BITS;

	logic [DATA_W-1:0]    a_abs, d_abs, high_part;
	logic                 ovf;
	logic [DATA_W-1:0]    rem_q, low_q, quo_q, d_q;
	logic                 neg_q, ovf_q, busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W:0]      rem_shift, rem_sub;
	logic                 ge;
	logic                 finish;
	logic signed [DATA_W-1:0] quot_q, result;

	assign a_abs     = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign d_abs     = divisor[DATA_W-1]  ? (~divisor + 1'b1)  : divisor;
	// upper quotient bits are nonzero when |num| >> 8 is already >= |den|
	assign high_part = {{HIGH_SHIFT{1'b0}}, a_abs[DATA_W-1:HIGH_SHIFT]};
	assign ovf       = (high_part >= d_abs);

	assign rem_shift = {rem_q, low_q[DATA_W-1]};
	assign rem_sub   = rem_shift - {1'b0, d_q};
	assign ge        = (rem_shift >= {1'b0, d_q});
	assign finish    = busy_q && (cnt_q == '0);

	always_comb begin
		if (neg_q) begin
			if (ovf_q || (quo_q > {1'b1, {(DATA_W-1){1'b0}}}))
				result = Q_MIN;
			else
				result = $signed(~quo_q + 1'b1);
		end else begin
			if (ovf_q || quo_q[DATA_W-1])
				result = Q_MAX;
			else
				result = $signed(quo_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= finish;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ovf ? '0 : DIV_CNT_W'(DIV_STEPS);
			end else if (finish) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= high_part;
			low_q <= {a_abs[HIGH_SHIFT-1:0], {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			d_q   <= d_abs;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			ovf_q <= ovf;
		end else if (busy_q && !finish) begin
			rem_q <= ge ? rem_sub[DATA_W-1:0] : rem_shift[DATA_W-1:0];
			low_q <= {low_q[DATA_W-2:0], 1'b0};
			quo_q <= {quo_q[DATA_W-2:0], ge};
		end
		if (finish)
			quot_q <= result;
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: rtl/core/tlu_datapath.sv
// Column datapath: input capture, pivot update, factorization state and result register.
module tlu_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tlu_pkg::dp_cmd_t                   cmd,
	input  logic signed [tlu_pkg::DATA_W-1:0]  diag_value,
	input  logic signed [tlu_pkg::DATA_W-1:0]  sub_value,
	input  logic signed [tlu_pkg::DATA_W-1:0]  super_value,
	input  logic                               first_column,
	input  logic                               last_column,
	input  logic signed [tlu_pkg::DATA_W-1:0]  quot,
	output logic                               need_div,
	output logic signed [tlu_pkg::DATA_W-1:0]  div_num,
	output logic signed [tlu_pkg::DATA_W-1:0]  div_den,
	output logic signed [tlu_pkg::DATA_W-1:0]  pivot_value,
	output logic signed [tlu_pkg::DATA_W-1:0]  multiplier,
	output logic [1:0]                         status,
	output logic [tlu_pkg::ROW_W-1:0]          failed_row,
	output logic                               last_result
);
	import tlu_pkg::*;

	localparam int PROD_W = 2 * DATA_W;
	localparam int SH_W   = PROD_W - FRAC_BITS;
	localparam int DIFF_W = SH_W + 2;
	localparam logic [ROW_W-1:0] COUNT_TOP = ROW_W'(MAX_COLUMNS - 1);

	// captured column
	logic signed [DATA_W-1:0] diag_q, sub_q, sup_q;
	logic                     start_q, last_q;
	// factorization state
	logic signed [DATA_W-1:0] prev_mult_q;
	logic [ROW_W-1:0]         count_q, fail_idx_q;
	logic                     failed_q;
	// arithmetic stages
	logic signed [PROD_W-1:0] prod_q;
	logic signed [DATA_W-1:0] pivot_q;
	// result register
	logic signed [DATA_W-1:0] pivot_out_q, mult_out_q;
	logic [1:0]               status_q;
	logic [ROW_W-1:0]         row_out_q;
	logic                     last_out_q;

	logic signed [DATA_W-1:0] m_eff;
	logic                     failed_eff;
	logic [ROW_W-1:0]         count_eff, fail_idx_eff, row_next;
	logic signed [SH_W-1:0]   prod_sh;
	logic                     round_adj;
	logic signed [SH_W:0]     prod_t;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DATA_W-1:0] pivot_sat;

	logic signed [DATA_W-1:0] r_pivot, r_mult, n_prev;
	logic [1:0]               r_status;
	logic [ROW_W-1:0]         r_row, n_count, n_fail_idx;
	logic                     n_failed;

	// a new matrix clears the running state
	assign m_eff        = start_q ? '0 : prev_mult_q;
	assign failed_eff   = start_q ? 1'b0 : failed_q;
	assign count_eff    = start_q ? '0 : count_q;
	assign fail_idx_eff = start_q ? '0 : fail_idx_q;
	assign row_next     = count_eff + 1'b1;

	// product / 2^24, truncated toward zero
	assign prod_sh   = prod_q[PROD_W-1:FRAC_BITS];
	assign round_adj = prod_q[PROD_W-1] && (prod_q[FRAC_BITS-1:0] != '0);
	assign prod_t    = {prod_sh[SH_W-1], prod_sh} + $signed({{SH_W{1'b0}}, round_adj});
	assign diff      = $signed({{(DIFF_W-DATA_W){diag_q[DATA_W-1]}}, diag_q})
	                 - $signed({prod_t[SH_W], prod_t});

	always_comb begin
		if (diff[DIFF_W-1:DATA_W-1] == {(DIFF_W-DATA_W+1){diff[DIFF_W-1]}})
			pivot_sat = diff[DATA_W-1:0];
		else
			pivot_sat = diff[DIFF_W-1] ? Q_MIN : Q_MAX;
	end

	assign need_div = !failed_eff && !last_q && (pivot_q != '0);
	assign div_num  = sub_q;
	assign div_den  = pivot_q;

	always_comb begin
		r_pivot    = '0;
		r_mult     = '0;
		r_status   = ST_OK;
		r_row      = '0;
		n_prev     = m_eff;
		n_count    = count_eff;
		n_failed   = failed_eff;
		n_fail_idx = fail_idx_eff;
		if (failed_eff) begin
			r_status = ST_SKIP;
			r_row    = fail_idx_eff;
		end else begin
			r_pivot = pivot_q;
			if (!last_q) begin
				if (pivot_q == '0) begin
					r_status   = ST_ZERO;
					r_row      = row_next;
					n_failed   = 1'b1;
					n_fail_idx = row_next;
					n_prev     = '0;
				end else begin
					r_mult = quot;
					n_prev = quot;
				end
				if (count_eff < COUNT_TOP)
					n_count = row_next;
			end
		end
		if (last_q) begin
			n_count = '0;
			n_prev  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mult_q <= '0;
			count_q     <= '0;
			failed_q    <= 1'b0;
			fail_idx_q  <= '0;
		end else if (cmd.commit) begin
			prev_mult_q <= n_prev;
			count_q     <= n_count;
			failed_q    <= n_failed;
			fail_idx_q  <= n_fail_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			diag_q  <= diag_value;
			sub_q   <= sub_value;
			sup_q   <= super_value;
			last_q  <= last_column;
			start_q <= first_column || (count_q == '0);
		end
		if (cmd.mul_en)
			prod_q <= m_eff * sup_q;
		if (cmd.piv_en)
			pivot_q <= pivot_sat;
		if (cmd.commit) begin
			pivot_out_q <= r_pivot;
			mult_out_q  <= r_mult;
			status_q    <= r_status;
			row_out_q   <= r_row;
			last_out_q  <= last_q;
		end
	end

	assign pivot_value = pivot_out_q;
	assign multiplier  = mult_out_q;
	assign status      = status_q;
	assign failed_row  = row_out_q;
	assign last_result = last_out_q;

endmodule

FILE: rtl/core/tlu_ctrl.sv
// Sequencing state machine and result-valid control.
module tlu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	input  tlu_pkg::dp_status_t  stat,
	output tlu_pkg::dp_cmd_t     cmd
);
	import tlu_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_PIV  = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;

	logic [2:0] state_q, state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || result_ready;

	always_comb begin
		state_nxt     = state_q;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load_in = item_valid;
				if (item_valid)
					state_nxt = S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				state_nxt  = S_PIV;
			end
			S_PIV: begin
				cmd.piv_en = 1'b1;
				state_nxt  = S_DEC;
			end
			S_DEC: begin
				cmd.div_start = stat.need_div;
				state_nxt     = stat.need_div ? S_DIV : S_FIN;
			end
			S_DIV: begin
				if (stat.div_done)
					state_nxt = S_FIN;
			end
			S_FIN: begin
				// hold here until the result register is free
				cmd.commit = out_free;
				if (out_free)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

endmodule

FILE: rtl/core/tridiagonal_lu_factor.sv
// Top level of the streaming tridiagonal LU factorization block.
//
// Input channel (item_valid/item_ready): one request per matrix column, carrying
// diag_value, sub_value, super_value (signed Q8.24) and the first/last markers.
// Output channel (result_valid/result_ready): one request per column with the
// pivot, the saturated multiplier, status, failed row and the last marker.
// Each column goes through product, pivot and decision steps, then the bit-serial
// divider if it needs a division (which ends early when the quotient is known to
// saturate up front), and is then loaded into the result register.
// One column is in flight at a time; throughput is set by the divider's 32-step
// restoring loop: the next column is taken in the cycle after the previous
// result is loaded.
// The output register lets a new column start while an earlier result waits;
// if the receiver stalls, a finished column holds in the final step until the
// register is taken, and no further column is accepted meanwhile.
// Reset clears the running multiplier, row count and failure flag, so the first
// column after reset starts a new matrix.
module tridiagonal_lu_factor (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  logic signed [tlu_pkg::DATA_W-1:0]  diag_value,
	input  logic signed [tlu_pkg::DATA_W-1:0]  sub_value,
	input  logic signed [tlu_pkg::DATA_W-1:0]  super_value,
	input  logic                               first_column,
	input  logic                               last_column,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [tlu_pkg::DATA_W-1:0]  pivot_value,
	output logic signed [tlu_pkg::DATA_W-1:0]  multiplier,
	output logic [1:0]                         status,
	output logic [tlu_pkg::ROW_W-1:0]          failed_row,
	output logic                               last_result
);
	import tlu_pkg::*;

	dp_cmd_t                  cmd;
	dp_status_t               stat;
	logic                     need_div, div_done;
	logic signed [DATA_W-1:0] div_num, div_den, quot;

	assign stat.need_div = need_div;
	assign stat.div_done = div_done;

	tlu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	tlu_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.diag_value   (diag_value),
		.sub_value    (sub_value),
		.super_value  (super_value),
		.first_column (first_column),
		.last_column  (last_column),
		.quot         (quot),
		.need_div     (need_div),
		.div_num      (div_num),
		.div_den      (div_den),
		.pivot_value  (pivot_value),
		.multiplier   (multiplier),
		.status       (status),
		.failed_row   (failed_row),
		.last_result  (last_result)
	);

	tlu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (quot)
	);

endmodule

FILE: rtl/core/tlu_checker.sv
// Port-level checks on the result channel of the factorization block, with bind.
module tlu_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               result_valid,
	input  logic                               result_ready,
	input  logic signed [tlu_pkg::DATA_W-1:0]  pivot_value,
	input  logic signed [tlu_pkg::DATA_W-1:0]  multiplier,
	input  logic [1:0]                         status,
	input  logic [tlu_pkg::ROW_W-1:0]          failed_row,
	input  logic                               last_result
);
	import tlu_pkg::*;

	// a stalled result request keeps its pivot, multiplier, status and failed row
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pivot_value)
			&& $stable(multiplier) && $stable(status) && $stable(failed_row))
		else $error("stalled result changed");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_ZERO) |->
			(pivot_value == '0) && (multiplier == '0) && (failed_row != '0) && !last_result)
		else $error("zero-pivot report malformed");

	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_SKIP) |->
			(pivot_value == '0) && (multiplier == '0) && (failed_row != '0))
		else $error("skipped column carries data");

	a_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_OK) |-> (failed_row == '0))
		else $error("failed row reported on good column");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |-> (multiplier == '0) && (status != ST_ZERO))
		else $error("last column gave a multiplier");

endmodule

bind tridiagonal_lu_factor tlu_checker u_tlu_checker (.*);
